[src/tsvf_pkg.sv]
// ----------------------------------------------------------------------------
// tsvf_pkg: shared types and constants of the text stream view filter
// Job descriptor passed from the classifier to the emitter, emit step
// positions, register indexes and ASCII codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tsvf_pkg;

  // Default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Emit steps, in output order. One mask bit per step.
  localparam int unsigned STEP_DIG0   = 0;   // most significant digit
  localparam int unsigned STEP_DIG5   = 5;   // least significant digit
  localparam int unsigned STEP_TAB    = 6;
  localparam int unsigned STEP_DOLLAR = 7;
  localparam int unsigned STEP_M      = 8;
  localparam int unsigned STEP_DASH   = 9;
  localparam int unsigned STEP_CARET  = 10;
  localparam int unsigned STEP_FIN    = 11;
  localparam int unsigned NUM_STEPS   = 12;
  localparam int unsigned STEP_W      = $clog2(NUM_STEPS);

  // ASCII codes
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_QMARK  = 8'd63;
  localparam logic [7:0] CH_UPPERI = 8'd73;
  localparam logic [7:0] CH_UPPERM = 8'd77;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_META   = 8'd128;
  localparam logic [7:0] CH_HIGH   = 8'd160;
  localparam logic [7:0] CTRL_OFS  = 8'd64;

  // Line counter, six BCD digits
  localparam logic [23:0] BCD_ONE = 24'h000001;
  localparam logic [23:0] BCD_MAX = 24'h999999;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_NONBLANK  = 3'd0,
    CFG_NUMBER_ALL       = 3'd1,
    CFG_SHOW_ENDS        = 3'd2,
    CFG_SQUEEZE_BLANK    = 3'd3,
    CFG_SHOW_TABS        = 3'd4,
    CFG_SHOW_NONPRINTING = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [NUM_STEPS-1:0] steps;   // bytes still to emit
    logic [23:0]          digits;  // line number, BCD
    logic [7:0]           fin;     // final byte of the run
  } job_t;

endpackage

`default_nettype wire

[src/tsvf_front.sv]
// ----------------------------------------------------------------------------
// tsvf_front: input classifier
// Holds the mode registers and the line state, decides squeeze, numbering
// and escapes for each input item and pushes one job per kept byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tsvf_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_valid_i,
  output logic                                   s_ready_o,
  input  wire logic [7:0]                        in_byte_i,
  input  wire logic                              file_start_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [tsvf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic                              cfg_data_i,
  output logic                                   push_o,
  output tsvf_pkg::job_t                         job_o,
  input  wire logic                              full_i
);
  import tsvf_pkg::*;

  function automatic logic [23:0] bcd_inc(input logic [23:0] v);
    logic [23:0] r;
    logic        carry;
    logic [3:0]  d;
    r     = '0;
    carry = 1'b1;
    if (v == BCD_MAX) begin
      r = BCD_MAX;
    end else begin
      for (int k = 0; k < 6; k++) begin
        d = v[4*k +: 4];
        if (carry && d == 4'd9) begin
          d = 4'd0;
        end else begin
          d     = d + {3'd0, carry};
          carry = 1'b0;
        end
        r[4*k +: 4] = d;
      end
    end
    return r;
  endfunction

  logic number_nonblank_q, number_all_q, show_ends_q;
  logic squeeze_blank_q, show_tabs_q, show_nonprinting_q;

  logic [7:0]  prev_q, prev_d;
  logic [1:0]  blank_q, blank_d;
  logic [23:0] lnum_q, lnum_d;

  logic        accept;
  logic [7:0]  prev_cur;
  logic [1:0]  blank_cur;
  logic [23:0] lnum_cur;
  logic        is_nl, at_start, do_num, drop;
  logic [7:0]  fin;
  logic [NUM_STEPS-1:0] steps;

  assign cfg_ready_o = 1'b1;
  assign s_ready_o   = !full_i;
  assign accept      = s_valid_i && s_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_nonblank_q  <= 1'b0;
      number_all_q       <= 1'b0;
      show_ends_q        <= 1'b0;
      squeeze_blank_q    <= 1'b0;
      show_tabs_q        <= 1'b0;
      show_nonprinting_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NUMBER_NONBLANK:  number_nonblank_q  <= cfg_data_i;
        CFG_NUMBER_ALL:       number_all_q       <= cfg_data_i;
        CFG_SHOW_ENDS:        show_ends_q        <= cfg_data_i;
        CFG_SQUEEZE_BLANK:    squeeze_blank_q    <= cfg_data_i;
        CFG_SHOW_TABS:        show_tabs_q        <= cfg_data_i;
        CFG_SHOW_NONPRINTING: show_nonprinting_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    // a new file starts from fresh line state
    prev_cur  = file_start_i ? CH_NL   : prev_q;
    blank_cur = file_start_i ? 2'd0    : blank_q;
    lnum_cur  = file_start_i ? BCD_ONE : lnum_q;
    is_nl     = (in_byte_i == CH_NL);

    if (squeeze_blank_q && is_nl && (prev_cur == CH_NL || prev_cur == CH_NUL)) begin
      blank_d = (blank_cur == 2'd2) ? 2'd2 : blank_cur + 2'd1;
    end else begin
      blank_d = 2'd0;
    end
    drop = (blank_d == 2'd2);

    at_start = (prev_cur == CH_NL);
    do_num   = (number_all_q && at_start && !number_nonblank_q) ||
               (number_nonblank_q && at_start && !is_nl);

    steps = '0;
    steps[STEP_FIN] = 1'b1;
    if (do_num) begin
      steps[STEP_DIG5:STEP_DIG0] = '1;
      steps[STEP_TAB]            = 1'b1;
    end
    steps[STEP_DOLLAR] = show_ends_q && is_nl;

    fin = in_byte_i;
    if (show_tabs_q && in_byte_i == CH_TAB) begin
      steps[STEP_CARET] = 1'b1;
      fin               = CH_UPPERI;
    end else if (show_nonprinting_q) begin
      if (in_byte_i < CH_SPACE && in_byte_i != CH_TAB && !is_nl) begin
        steps[STEP_CARET] = 1'b1;
        fin               = in_byte_i + CTRL_OFS;
      end else if (in_byte_i == CH_DEL) begin
        steps[STEP_CARET] = 1'b1;
        fin               = CH_QMARK;
      end else if (in_byte_i >= CH_META && in_byte_i < CH_HIGH) begin
        steps[STEP_M]     = 1'b1;
        steps[STEP_DASH]  = 1'b1;
        steps[STEP_CARET] = 1'b1;
        fin               = in_byte_i - CTRL_OFS;
      end
    end

    // a dropped newline leaves the rest of the state as it was
    prev_d = drop ? prev_cur : fin;
    lnum_d = (!drop && do_num) ? bcd_inc(lnum_cur) : lnum_cur;

    push_o       = accept && !drop;
    job_o.steps  = steps;
    job_o.digits = lnum_cur;
    job_o.fin    = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= CH_NL;
      blank_q <= 2'd0;
      lnum_q  <= BCD_ONE;
    end else if (accept) begin
      prev_q  <= prev_d;
      blank_q <= blank_d;
      lnum_q  <= lnum_d;
    end
  end

endmodule

`default_nettype wire

[src/tsvf_queue.sv]
// ----------------------------------------------------------------------------
// tsvf_queue: job queue
// Small circular buffer decoupling the classifier from the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module tsvf_queue #(
  parameter int unsigned Depth = tsvf_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tsvf_pkg::job_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output tsvf_pkg::job_t      head_o,
  output logic                empty_o
);
  import tsvf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t mem_q [Depth];

  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ((wr_q == LastPtr) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop_i  ? ((rd_q == LastPtr) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job popped from empty queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != FullCnt) |-> (wr_q != rd_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[src/tsvf_back.sv]
// ----------------------------------------------------------------------------
// tsvf_back: run emitter
// Takes jobs from the queue and sends their bytes one per cycle while the
// receiver is ready, through a registered output stage, tlast on a run's final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tsvf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  input  wire tsvf_pkg::job_t job_i,
  output logic                pop_o,
  output logic                m_valid_o,
  input  wire logic           m_ready_i,
  output logic [7:0]          m_data_o,
  output logic                m_last_o
);
  import tsvf_pkg::*;

  job_t                 job_q, job_d;
  logic [NUM_STEPS-1:0] rest;
  logic                 active, advance, emit, last;
  logic [STEP_W-1:0]    step;
  logic [7:0]           digit_ch [6];
  logic                 seen;
  logic [3:0]           d;
  logic [7:0]           ch;

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;

  always_comb begin
    active  = |job_q.steps;
    advance = !valid_q || m_ready_i;
    emit    = active && advance;
    rest    = job_q.steps & (job_q.steps - 1'b1);
    last    = (rest == '0);

    // lowest pending step goes out first
    step = '0;
    for (int k = NUM_STEPS - 1; k >= 0; k--) begin
      if (job_q.steps[k]) begin
        step = STEP_W'(k);
      end
    end

    // leading zero digits print as spaces, units digit always shown
    seen = 1'b0;
    for (int k = 0; k < 6; k++) begin
      d = job_q.digits[4*(5-k) +: 4];
      if (d != 4'd0 || k == 5) begin
        seen = 1'b1;
      end
      digit_ch[k] = seen ? (CH_ZERO + {4'd0, d}) : CH_SPACE;
    end

    case (step)
      STEP_W'(STEP_TAB):    ch = CH_TAB;
      STEP_W'(STEP_DOLLAR): ch = CH_DOLLAR;
      STEP_W'(STEP_M):      ch = CH_UPPERM;
      STEP_W'(STEP_DASH):   ch = CH_DASH;
      STEP_W'(STEP_CARET):  ch = CH_CARET;
      STEP_W'(STEP_FIN):    ch = job_q.fin;
      default:              ch = (step <= STEP_W'(STEP_DIG5)) ? digit_ch[step[2:0]]
                                                              : job_q.fin;
    endcase

    pop_o = job_valid_i && (!active || (emit && last));

    job_d = job_q;
    if (pop_o) begin
      job_d = job_i;
    end else if (emit) begin
      job_d.steps = rest;
    end

    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    if (emit) begin
      valid_d = 1'b1;
      data_d  = ch;
      last_d  = last;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      job_q   <= job_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_last_o  = last_q;

endmodule

`default_nettype wire

[src/text_stream_view_filter.sv]
// ----------------------------------------------------------------------------
// text_stream_view_filter: byte stream text viewing filter
// Line numbering, blank line squeeze and visible control characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one file byte per item, tuser flags the first
//   byte of a new file (line state cleared before that byte is handled).
//   Output stream m_axis_*: each input byte gives 0 to 11 output items;
//   tlast marks the final item of that byte's run. A squeezed newline
//   gives no items.
//   Config port cfg_*: index 0..5 selects number_nonblank, number_all,
//   show_ends, squeeze_blank, show_tabs, show_nonprinting; bit 0 of the
//   data is written. Always ready; write only while the filter is idle.
// Timing:
//   After an input item is accepted, its first output item passes the queue
//   write, the emitter load and the output register, in that order. The
//   emitter sends one item per cycle while the receiver is ready, so a byte
//   producing a single item sustains one input per cycle.
//   Input ready drops only when the job queue (QueueDepth entries) fills.
// Reset: modes off, line counter 1, previous byte newline, queue empty.
//   A stalled receiver holds the output register; the queue then fills
//   and backpressures the input.
// ----------------------------------------------------------------------------
`default_nettype none

module text_stream_view_filter #(
  parameter int unsigned QueueDepth = tsvf_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,   // [7:0] in_byte
  input  wire logic                            s_axis_tuser,   // [0] file_start
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata,   // [7:0] out_byte
  output logic                                 m_axis_tlast,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tsvf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic                            cfg_data_i
);
  import tsvf_pkg::*;

  logic push, full, pop, empty;
  job_t push_job, head_job;

  tsvf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .file_start_i (s_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_o       (push),
    .job_o        (push_job),
    .full_i       (full)
  );

  tsvf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head_job),
    .empty_o     (empty)
  );

  tsvf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

`default_nettype wire

[sim/tsvf_view_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsvf_view_checker: output checker for the text stream view filter
// Watches the input, output and register channels. Keeps its own copy of
// the mode bits and line state, turns every accepted input byte into the
// output items it must give, and compares them in order with the output.
// ----------------------------------------------------------------------------

module tsvf_view_checker
  import tsvf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire logic [7:0]           in_byte_i,
  input  wire logic                 in_start_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire logic [7:0]           out_byte_i,
  input  wire logic                 out_last_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic                 cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic                 cfg_data_i,
  output int                        mismatch_cnt_o,
  output int                        owed_cnt_o,
  output int                        checked_cnt_o
);

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } view_item_t;

  view_item_t owed_bytes[$];

  logic mode_nonblank = 1'b0;
  logic mode_all      = 1'b0;
  logic mode_ends     = 1'b0;
  logic mode_squeeze  = 1'b0;
  logic mode_tabs     = 1'b0;
  logic mode_nonprint = 1'b0;

  logic [7:0]  prev_out  = CH_NL;
  logic [1:0]  blank_cnt = 2'd0;
  logic [23:0] line_bcd  = BCD_ONE;

  initial begin
    mismatch_cnt_o = 0;
    owed_cnt_o     = 0;
    checked_cnt_o  = 0;
  end

  function automatic logic [23:0] bcd_next(input logic [23:0] v);
    logic [23:0] r;
    logic [4:0]  d;
    logic        carry;
    int          k;
    if (v >= BCD_MAX) return BCD_MAX;
    r     = '0;
    carry = 1'b1;
    for (k = 0; k < 6; k++) begin
      d = {1'b0, v[4*k +: 4]} + carry;
      if (d > 5'd9) begin
        d     = '0;
        carry = 1'b1;
      end else begin
        carry = 1'b0;
      end
      r[4*k +: 4] = d[3:0];
    end
    return r;
  endfunction

  task automatic owe(input logic [7:0] b, input logic last);
    owed_bytes.push_back('{data: b, last: last});
  endtask

  // Expected output run for one accepted input byte.
  task automatic render_byte(input logic [7:0] c, input logic fresh);
    logic       is_nl;
    logic       lead;
    logic [3:0] dig;
    logic [7:0] fin;
    int         k;
    if (fresh) begin
      prev_out  = CH_NL;
      blank_cnt = 2'd0;
      line_bcd  = BCD_ONE;
    end
    is_nl = (c == CH_NL);
    if (mode_squeeze && is_nl && (prev_out == CH_NL || prev_out == CH_NUL)) begin
      if (blank_cnt < 2'd2) blank_cnt = blank_cnt + 2'd1;
    end else begin
      blank_cnt = 2'd0;
    end
    // second blank line in a row while squeezing: nothing comes out
    if (blank_cnt < 2'd2) begin
      fin = c;
      if (prev_out == CH_NL &&
          ((mode_all && !mode_nonblank) || (mode_nonblank && !is_nl))) begin
        lead = 1'b1;
        for (k = 5; k >= 0; k--) begin
          dig = line_bcd[4*k +: 4];
          if (dig > 4'd9) dig = 4'd9;
          if (dig != 4'd0 || k == 0) lead = 1'b0;
          owe(lead ? CH_SPACE : CH_ZERO + dig, 1'b0);
        end
        owe(CH_TAB, 1'b0);
        line_bcd = bcd_next(line_bcd);
      end
      if (mode_ends && is_nl) owe(CH_DOLLAR, 1'b0);
      if (mode_tabs && c == CH_TAB) begin
        owe(CH_CARET, 1'b0);
        fin = CH_UPPERI;
      end else if (mode_nonprint) begin
        if (c < CH_SPACE && c != CH_TAB && c != CH_NL) begin
          owe(CH_CARET, 1'b0);
          fin = c + CTRL_OFS;
        end else if (c == CH_DEL) begin
          owe(CH_CARET, 1'b0);
          fin = CH_QMARK;
        end else if (c >= CH_META && c < CH_HIGH) begin
          owe(CH_UPPERM, 1'b0);
          owe(CH_DASH, 1'b0);
          owe(CH_CARET, 1'b0);
          fin = c - CTRL_OFS;
        end
      end
      owe(fin, 1'b1);
      prev_out = fin;
    end
  endtask

  task automatic flag_error(input string what);
    mismatch_cnt_o++;
    if (mismatch_cnt_o <= MAX_REPORTS)
      $display("[%0t] ERROR at output item %0d: %s", $time, checked_cnt_o, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    view_item_t exp_item;
    if (!rst_ni) begin
      mode_nonblank = 1'b0;
      mode_all      = 1'b0;
      mode_ends     = 1'b0;
      mode_squeeze  = 1'b0;
      mode_tabs     = 1'b0;
      mode_nonprint = 1'b0;
      prev_out      = CH_NL;
      blank_cnt     = 2'd0;
      line_bcd      = BCD_ONE;
      owed_bytes.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_bytes.size() == 0) begin
          flag_error($sformatf("unexpected item out_byte=%02h last=%0b",
                               out_byte_i, out_last_i));
        end else begin
          exp_item = owed_bytes.pop_front();
          if (out_byte_i !== exp_item.data)
            flag_error($sformatf("out_byte expected %02h got %02h",
                                 exp_item.data, out_byte_i));
          if (out_last_i !== exp_item.last)
            flag_error($sformatf("last_of_run expected %0b got %0b",
                                 exp_item.last, out_last_i));
        end
        checked_cnt_o++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_NUMBER_NONBLANK:  mode_nonblank = cfg_data_i;
          CFG_NUMBER_ALL:       mode_all      = cfg_data_i;
          CFG_SHOW_ENDS:        mode_ends     = cfg_data_i;
          CFG_SQUEEZE_BLANK:    mode_squeeze  = cfg_data_i;
          CFG_SHOW_TABS:        mode_tabs     = cfg_data_i;
          CFG_SHOW_NONPRINTING: mode_nonprint = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) render_byte(in_byte_i, in_start_i);
    end
    owed_cnt_o = owed_bytes.size();
  end

endmodule

[sim/tb_text_stream_view_filter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_stream_view_filter: testbench of the text stream view filter
// Directed bytes for every display mode and squeeze case, then random text
// lines under a series of mode settings, with random gaps on the input and
// random stalls on the output. Checking is done by tsvf_view_checker.
// ----------------------------------------------------------------------------

module tb_text_stream_view_filter;
  import tsvf_pkg::*;

  localparam int unsigned CLK_HALF        = 6;
  localparam int unsigned RESET_CYCLES    = 5;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned BYTES_PER_PHASE = 48;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;   // [7:0] in_byte
  logic                 s_axis_tuser  = 1'b0; // [0] file_start
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;         // [7:0] out_byte
  logic                 m_axis_tlast;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic                 cfg_data_i    = 1'b0;

  int   mismatch_cnt;
  int   owed_cnt;
  int   checked_cnt;
  int   quiet_cycles  = 0;
  int   rx_hold       = 0;
  int   line_left     = 0;
  int   bytes_sent    = 0;
  int   files_started = 0;
  int   reg_writes    = 0;
  int   mode_sets     = 0;
  logic idle_en       = 1'b1;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  text_stream_view_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  tsvf_view_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_i     (s_axis_tready),
    .in_byte_i      (s_axis_tdata),
    .in_start_i     (s_axis_tuser),
    .out_valid_i    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_byte_i     (m_axis_tdata),
    .out_last_i     (m_axis_tlast),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatch_cnt),
    .owed_cnt_o     (owed_cnt),
    .checked_cnt_o  (checked_cnt)
  );

  // mostly no gap, some short ones, a few long
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Text lines of random length and content, blank lines included,
  // with some fully random bytes mixed in.
  function automatic logic [7:0] next_text_byte();
    int r;
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
    if (line_left == 0) begin
      if ($urandom_range(0, 2) == 0) line_left = 0;
      else if ($urandom_range(0, 9) == 0) line_left = $urandom_range(16, 40);
      else line_left = $urandom_range(1, 8);
      return CH_NL;
    end
    line_left--;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(CH_SPACE, CH_DEL - 1));
    if (r < 63) return CH_TAB;
    if (r < 71) return 8'($urandom_range(0, CH_SPACE - 1));
    if (r < 76) return CH_DEL;
    if (r < 86) return 8'($urandom_range(CH_META, CH_HIGH - 1));
    return 8'($urandom_range(CH_HIGH, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    gap = idle_en ? pick_idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= fs;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    if (fs) files_started++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reg_writes++;
  endtask

  // Waits for the filter to go idle, then writes all six mode bits
  // (bit i of modes goes to register i) and one unused index.
  task automatic set_modes(input logic [5:0] modes);
    int i;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (owed_cnt == 0);
    // squeezed newlines give no item, so allow the pipeline to empty
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (i = CFG_NUMBER_NONBLANK; i <= CFG_SHOW_NONPRINTING; i++)
      write_reg(CFG_IDX_W'(i), modes[i]);
    write_reg(CFG_IDX_W'($urandom_range(CFG_SHOW_NONPRINTING + 1, 2**CFG_IDX_W - 1)),
              1'($urandom_range(0, 1)));
    cfg_valid_i <= 1'b0;
    mode_sets++;
  endtask

  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= pick_idle_len();
    end else begin
      m_axis_tready <= 1'b1;
      rx_hold       <= idle_en ? $urandom_range(0, 5) : 0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles, %0d output items outstanding",
               quiet_cycles, owed_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int   ph;
    int   n;
    logic fs;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // everything but nonblank: numbers, ends, squeeze, tabs, control forms
    set_modes(6'b111110);
    send_byte(CH_NUL, 1'b1);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(CH_DEL, 1'b0);
    send_byte(CH_META, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(CH_HIGH, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_NL, 1'b0);

    // nonblank over all, squeeze after a raw NUL, raw tab
    set_modes(6'b001011);
    send_byte(CH_NL, 1'b1);
    send_byte(CH_NUL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_NL, 1'b0);

    // plain pass-through
    set_modes(6'b000000);
    send_byte(8'h1B, 1'b0);
    send_byte(CH_META, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(8'hFF, 1'b1);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_en = (ph % 3 != 2);
      if (ph == 0) set_modes(6'b111111);
      else if (ph == 1) set_modes(6'b000000);
      else set_modes(6'($urandom_range(0, 63)));
      for (n = 0; n < BYTES_PER_PHASE; n++) begin
        fs = ($urandom_range(0, 39) == 0);
        send_byte(next_text_byte(), fs);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (owed_cnt == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d input bytes (%0d file starts) under %0d mode settings, %0d reg writes",
             bytes_sent, files_started, mode_sets, reg_writes);
    $display("Compared %0d output items, %0d mismatches", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && owed_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
